// File: src/assert_macros.svh
// Assertion helpers shared by the RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define AST_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// The expression must never be true outside reset.
`define AST_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define AST_HOLDS(label, clk, rst, prop)
`define AST_NEVER(label, clk, rst, expr)

`endif

`endif

// File: src/dmr_hc_pkg.sv
package dmr_hc_pkg;

   localparam int NUM_CODES = 5;
   localparam int MAX_K     = 12;
   localparam int PAR_W     = 5;
   localparam int WORD_W    = 17;
   localparam int KIND_W    = 3;

   typedef logic [PAR_W-1:0]  par_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef logic [KIND_W-1:0] kind_type;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FIXED = 2'd1,
      STATUS_BAD   = 2'd2
   } status_type;

   typedef struct packed {
      word_type   word;
      status_type status;
   } result_type;

   // Generator rows per code, data bit 0 first; unused slots are zero
   localparam par_type GEN_TABLE [NUM_CODES][MAX_K] = '{
      '{5'h03, 5'h06, 5'h07, 5'h05, 5'h00, 5'h00,
        5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
      '{5'h03, 5'h06, 5'h0C, 5'h0B, 5'h05, 5'h0A,
        5'h07, 5'h0E, 5'h0F, 5'h00, 5'h00, 5'h00},
      '{5'h03, 5'h06, 5'h0C, 5'h0B, 5'h05, 5'h0A,
        5'h07, 5'h0E, 5'h0F, 5'h0D, 5'h09, 5'h00},
      '{5'h07, 5'h0D, 5'h19, 5'h16, 5'h0B, 5'h15,
        5'h0E, 5'h1C, 5'h1F, 5'h1A, 5'h13, 5'h00},
      '{5'h05, 5'h0A, 5'h14, 5'h0D, 5'h1A, 5'h11,
        5'h07, 5'h0E, 5'h1C, 5'h1D, 5'h1F, 5'h1B}
   };

   // Data bits, parity bits and extended flag per code
   localparam int CODE_K [NUM_CODES] = '{4, 9, 11, 11, 12};
   localparam int CODE_P [NUM_CODES] = '{3, 4, 4, 5, 5};
   localparam bit CODE_EXT [NUM_CODES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

   // Encode or decode one word with a fixed code
   function automatic result_type hc_process(input int code, input op_type op,
                                             input word_type word);
      result_type res;
      par_type    acc;
      par_type    pmask;
      par_type    syn;
      word_type   nmask;
      word_type   enc;
      logic       dbit;
      logic       found;
      int         kk;
      int         pp;
      kk    = CODE_K[code];
      pp    = CODE_P[code];
      acc   = '0;
      enc   = '0;
      found = 1'b0;
      pmask = PAR_W'((1 << pp) - 1);
      nmask = WORD_W'((64'd1 << (kk + pp)) - 64'd1);
      // XOR the generator rows of all set data bits
      for (int i = 0; i < MAX_K; i++) begin
         if (i < kk) begin
            dbit = (op == OP_DECODE) ? word[pp + i] : word[i];
            if (dbit) begin
               acc = acc ^ GEN_TABLE[code][i];
            end
            enc[pp + i] = dbit;
         end
      end
      res.word   = word;
      res.status = STATUS_BAD;
      if (op == OP_ENCODE) begin
         res.word   = enc | WORD_W'(acc & pmask);
         res.status = STATUS_OK;
      end else begin
         syn = (word[PAR_W-1:0] & pmask) ^ acc;
         if (syn == '0) begin
            res.status = STATUS_OK;
         end else if (CODE_EXT[code] && !(^(word & nmask))) begin
            res.status = STATUS_BAD;
         end else begin
            // Data-bit match takes precedence over a parity-bit match
            for (int i = 0; i < MAX_K; i++) begin
               if (i < kk && !found && syn == GEN_TABLE[code][i]) begin
                  res.word = word ^ (WORD_W'(1) << (pp + i));
                  found    = 1'b1;
               end
            end
            for (int i = 0; i < PAR_W; i++) begin
               if (i < pp && !found && syn == (PAR_W'(1) << i)) begin
                  res.word = word ^ (WORD_W'(1) << i);
                  found    = 1'b1;
               end
            end
            res.status = found ? STATUS_FIXED : STATUS_BAD;
         end
      end
      return res;
   endfunction

endpackage

// File: src/dmr_hamming_codec.sv
// DMR Hamming encoder and decoder for the (7,4), (13,9), (15,11), (16,11) and (17,12) codes.
// Pipeline: input register, then result register, between an input transfer and its result.
// Throughput: one item per cycle while rsp_tready is high; parity and syndrome logic sits between the two registers.
// Reset: synchronous, active high; clears both valid flags, payload registers are not reset.
`include "assert_macros.svh"

module dmr_hamming_codec
   import dmr_hc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [16:0] word_in, [23:17] zero
   input  logic [3:0]  req_tuser,  // [0] mode, [3:1] code_kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [16:0] word_out, [23:17] zero
   output logic [1:0]  rsp_tuser   // [1:0] status
);

   logic       s1_valid_ff;
   logic       s1_valid_in;
   op_type     s1_op_ff;
   kind_type   s1_kind_ff;
   word_type   s1_word_ff;
   logic       s2_valid_ff;
   logic       s2_valid_in;
   result_type s2_res_ff;
   logic       s1_load;
   logic       s2_load;
   result_type code_res [NUM_CODES];
   result_type sel_res;

   // Advance stages when the next one is empty or draining
   assign s2_load    = s1_valid_ff && (!s2_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s2_load;
   assign s1_load    = req_tvalid && req_tready;

   assign s1_valid_in = s1_load || (s1_valid_ff && !s2_load);
   assign s2_valid_in = s2_load || (s2_valid_ff && !rsp_tready);

   // Hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Capture the input transfer
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_op_ff   <= op_type'(req_tuser[0]);
         s1_kind_ff <= req_tuser[3:1];
         s1_word_ff <= req_tdata[WORD_W-1:0];
      end
   end

   // Run every code in parallel, then pick the selected one
   always_comb begin
      for (int c = 0; c < NUM_CODES; c++) begin
         code_res[c] = hc_process(c, s1_op_ff, s1_word_ff);
      end
      if (s1_kind_ff < KIND_W'(NUM_CODES)) begin
         sel_res = code_res[s1_kind_ff];
      end else begin
         sel_res.word   = s1_word_ff;
         sel_res.status = STATUS_BAD;
      end
   end

   // Capture the result
   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_res_ff <= sel_res;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {{(24 - WORD_W){1'b0}}, s2_res_ff.word};
   assign rsp_tuser  = s2_res_ff.status;

   `AST_HOLDS(a_encode_ok, clock, reset,
      (s1_valid_ff && s1_op_ff == OP_ENCODE && s1_kind_ff < KIND_W'(NUM_CODES))
      |-> sel_res.status == STATUS_OK)
   `AST_HOLDS(a_bad_unchanged, clock, reset,
      (s1_valid_ff && sel_res.status == STATUS_BAD) |-> sel_res.word == s1_word_ff)
   `AST_HOLDS(a_fix_one_bit, clock, reset,
      (s1_valid_ff && sel_res.status == STATUS_FIXED)
      |-> $onehot(sel_res.word ^ s1_word_ff))
   `AST_HOLDS(a_decode_clean, clock, reset,
      (s1_valid_ff && s1_op_ff == OP_DECODE && sel_res.status == STATUS_OK)
      |-> sel_res.word == s1_word_ff)
   `AST_HOLDS(a_stall_keeps_item, clock, reset,
      (s1_valid_ff && !s2_load) |=> (s1_valid_ff && $stable(s1_word_ff)))

endmodule
